// ===== hdl/cct_pkg.sv =====
// Package with the shared types and character constants of the CSV cell tokenizer.
package cct_pkg;

    // Characters that the tokenizer reacts to.
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;

    // Kind of a result beat.
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_CELL = 2'd1,
        KIND_ROW  = 2'd2
    } t_kind;

    // One result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        logic       last;
    } t_result;

endpackage

// ===== hdl/cct_if.sv =====
// Valid/ready channel interfaces for the input bytes and the result beats.
interface cct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface cct_out_if;
    logic          valid;
    logic          ready;
    logic [7:0]    out_byte;
    cct_pkg::t_kind kind;
    logic          last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

// ===== hdl/csv_cell_tokenizer_top.sv =====
// CSV cell tokenizer: splits a byte stream into cell bytes, cell ends and row ends.
//
//   channel | dir | payload                       | accepted when
//   i_in    | in  | data_byte, end_of_data        | valid && ready
//   o_out   | out | out_byte, kind, last          | valid && ready
//
// Every input beat is decoded combinationally; its zero to three results are
// written to a four-entry result queue whose head drives o_out.
// An input beat is taken whenever the queue holds at most one result, so a stalled
// output does not stop the input until two results are waiting.
// A byte that makes one result sustains one beat per cycle while o_out is ready;
// cell and row ends with three results take three beats of the one output port.
// Reset (i_rst_n low, synchronous) empties the queue and clears the tokenizer state.
module csv_cell_tokenizer_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cct_in_if.sink           i_in,
    cct_out_if.source        o_out
);

    localparam int unsigned QDepth = 4;

    // Tokenizer state.
    logic       r_in_cell, n_in_cell;
    logic       r_quote, n_quote;
    logic [7:0] r_held_byte, n_held_byte;
    logic       r_held_valid, n_held_valid;
    logic       r_row_open, n_row_open;

    // Result queue.
    cct_pkg::t_result r_q [QDepth];
    cct_pkg::t_result n_q [QDepth];
    logic [2:0]       r_cnt, n_cnt;

    // Results of the current beat.
    cct_pkg::t_result res [3];
    logic [1:0]       res_n;

    logic       in_acc;
    logic       out_acc;
    logic [7:0] b;
    logic       is_brk;
    logic       merge;
    logic       f_append, f_flush, f_cell, f_row, f_reset;
    logic [1:0] base;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign b       = i_in.data_byte;
    assign is_brk  = (b == cct_pkg::CH_CR) || (b == cct_pkg::CH_LF);
    assign merge   = r_held_valid && (r_held_byte == cct_pkg::CH_BSLASH)
                     && (b == cct_pkg::CH_LOWER_N);

    // Decode the beat into the actions it takes, in the order they apply.
    always_comb begin
        f_append = 1'b0;
        f_flush  = 1'b0;
        f_cell   = 1'b0;
        f_row    = 1'b0;
        f_reset  = 1'b0;
        n_in_cell  = r_in_cell;
        n_quote    = r_quote;
        n_row_open = r_row_open;
        if (i_in.end_of_data) begin
            if (r_in_cell && r_held_valid) begin
                f_flush = 1'b1;
                f_cell  = 1'b1;
                f_row   = 1'b1;
            end else if (r_row_open) begin
                f_row = 1'b1;
            end
            f_reset = 1'b1;
        end else if (!r_in_cell) begin
            if (is_brk) begin
                // Line breaks at the start of a cell are skipped.
            end else if (b == cct_pkg::CH_QUOTE) begin
                n_in_cell = 1'b1;
                n_quote   = 1'b1;
            end else if (b == cct_pkg::CH_COMMA) begin
                f_cell     = 1'b1;
                n_row_open = 1'b1;
            end else begin
                n_in_cell = 1'b1;
                n_quote   = 1'b0;
                f_append  = 1'b1;
            end
        end else begin
            if (b == cct_pkg::CH_QUOTE) begin
                n_quote  = ~r_quote;
                f_append = ~r_quote;
            end else if (b == cct_pkg::CH_COMMA) begin
                if (r_quote) begin
                    f_append = 1'b1;
                end else begin
                    f_flush    = 1'b1;
                    f_cell     = 1'b1;
                    n_in_cell  = 1'b0;
                    n_row_open = 1'b1;
                end
            end else if (is_brk) begin
                f_flush = 1'b1;
                f_cell  = 1'b1;
                f_row   = 1'b1;
                f_reset = 1'b1;
            end else begin
                f_append = 1'b1;
            end
        end
    end

    // Build the result list and the held byte from the decoded actions.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            res[k] = '{out_byte: 8'h00, kind: cct_pkg::KIND_BYTE, last: 1'b0};
        end
        res_n        = 2'd0;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        if (f_append) begin
            if (merge) begin
                // A backslash followed by 'n' turns into a newline byte.
                n_held_byte = cct_pkg::CH_LF;
            end else begin
                if (r_held_valid) begin
                    res[res_n].out_byte = r_held_byte;
                    res_n = res_n + 2'd1;
                end
                n_held_byte  = b;
                n_held_valid = 1'b1;
            end
        end
        if (f_flush) begin
            if (r_held_valid) begin
                res[res_n].out_byte = r_held_byte;
                res_n = res_n + 2'd1;
            end
            n_held_byte  = 8'h00;
            n_held_valid = 1'b0;
        end
        if (f_cell) begin
            res[res_n].kind = cct_pkg::KIND_CELL;
            res_n = res_n + 2'd1;
        end
        if (f_row) begin
            res[res_n].kind = cct_pkg::KIND_ROW;
            res_n = res_n + 2'd1;
        end
        if (res_n != 2'd0) begin
            res[res_n - 2'd1].last = 1'b1;
        end
    end

    // Next queue contents: pop the head, then append this beat's results.
    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (out_acc) begin
            for (int i = 0; i < QDepth - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
            n_cnt = r_cnt - 3'd1;
        end
        base = n_cnt[1:0];
        if (in_acc) begin
            for (int j = 0; j < 3; j++) begin
                if (2'(j) < res_n) begin
                    n_q[base + 2'(j)] = res[j];
                end
            end
            n_cnt = n_cnt + {1'b0, res_n};
        end
    end

    // State and queue registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cell    <= 1'b0;
            r_quote      <= 1'b0;
            r_held_byte  <= 8'h00;
            r_held_valid <= 1'b0;
            r_row_open   <= 1'b0;
            r_cnt        <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
            if (in_acc) begin
                if (f_reset) begin
                    r_in_cell    <= 1'b0;
                    r_quote      <= 1'b0;
                    r_held_byte  <= 8'h00;
                    r_held_valid <= 1'b0;
                    r_row_open   <= 1'b0;
                end else begin
                    r_in_cell    <= n_in_cell;
                    r_quote      <= n_quote;
                    r_held_byte  <= n_held_byte;
                    r_held_valid <= n_held_valid;
                    r_row_open   <= n_row_open;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    // Channel outputs.
    assign i_in.ready     = (r_cnt <= 3'd1);
    assign o_out.valid    = (r_cnt != 3'd0);
    assign o_out.out_byte = r_q[0].out_byte;
    assign o_out.kind     = r_q[0].kind;
    assign o_out.last     = r_q[0].last;

endmodule

// ===== hdl/cct_checker.sv =====
// Port-level checker for the CSV cell tokenizer and its bind to the top level.
module cct_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input logic [7:0]     i_out_byte,
    input cct_pkg::t_kind i_out_kind,
    input logic           i_out_last
);

    // The result queue is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result beat shown right after reset");

    // With no result waiting, the input side must be open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while no result waits");

    // Markers carry a zero byte, and a row end always closes the beat's results.
    a_marker_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind != cct_pkg::KIND_BYTE) |-> (i_out_byte == 8'h00))
        else $error("marker beat with nonzero byte");

    a_row_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind == cct_pkg::KIND_ROW) |-> i_out_last)
        else $error("row end not marked last");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_byte) && $stable(i_out_kind) && $stable(i_out_last)))
        else $error("stalled result beat changed");

endmodule

bind csv_cell_tokenizer_top cct_checker u_cct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_kind  (o_out.kind),
    .i_out_last  (o_out.last)
);
